@@ sv/pbp_pkg.sv @@
package pbp_pkg;

   localparam int unsigned AddrW      = 32;
   localparam logic [4:0]  AddrMult   = 5'd19;
   localparam int unsigned ThreshW    = 12;
   localparam logic [11:0] ThreshReset = 12'd52;
   localparam int unsigned SumFieldW  = 13;

   typedef enum logic [8:0] {
      S_CLEAR  = 9'b000000001,
      S_IDLE   = 9'b000000010,
      S_HASH   = 9'b000000100,
      S_SCALE  = 9'b000001000,
      S_READ   = 9'b000010000,
      S_GROUP  = 9'b000100000,
      S_TOTAL  = 9'b001000000,
      S_DECIDE = 9'b010000000,
      S_COMMIT = 9'b100000000
   } state_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic read;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_busy;
   } status_type;

endpackage

@@ sv/pbp_ram.sv @@
module pbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/pbp_ctrl.sv @@
module pbp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output pbp_pkg::cmd_type     cmd,
   input  pbp_pkg::status_type  status
);

   pbp_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pbp_pkg::S_CLEAR: begin
            if (status.clear_last) begin
               state_in = pbp_pkg::S_IDLE;
            end
         end
         pbp_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = pbp_pkg::S_HASH;
            end
         end
         pbp_pkg::S_HASH:   state_in = pbp_pkg::S_SCALE;
         pbp_pkg::S_SCALE:  state_in = pbp_pkg::S_READ;
         pbp_pkg::S_READ:   state_in = pbp_pkg::S_GROUP;
         pbp_pkg::S_GROUP:  state_in = pbp_pkg::S_TOTAL;
         pbp_pkg::S_TOTAL:  state_in = pbp_pkg::S_DECIDE;
         pbp_pkg::S_DECIDE: state_in = pbp_pkg::S_COMMIT;
         pbp_pkg::S_COMMIT: begin
            // hold here while the previous result is still unclaimed
            if (!status.out_busy) begin
               state_in = pbp_pkg::S_IDLE;
            end
         end
         default: state_in = pbp_pkg::S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbp_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready  = (state_ff == pbp_pkg::S_IDLE);
   assign cmd.load   = req_valid & req_ready;
   assign cmd.clear  = (state_ff == pbp_pkg::S_CLEAR);
   assign cmd.read   = (state_ff == pbp_pkg::S_READ);
   assign cmd.commit = (state_ff == pbp_pkg::S_COMMIT) & ~status.out_busy;

endmodule

@@ sv/pbp_datapath.sv @@
module pbp_datapath #(
   parameter int TABLE_ROWS  = 512,
   parameter int HISTORY_LEN = 20,
   parameter int WEIGHT_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pbp_pkg::cmd_type                     cmd,
   output pbp_pkg::status_type                  status,
   input  logic [pbp_pkg::AddrW-1:0]            req_branch_address,
   input  logic                                 req_branch_taken,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic                                 rsp_predicted_taken,
   output logic signed [pbp_pkg::SumFieldW-1:0] rsp_weighted_sum,
   output logic                                 rsp_weights_updated,
   input  logic                                 csr_write_enable,
   input  logic [pbp_pkg::ThreshW-1:0]          csr_write_data
);

   localparam int IdxW      = $clog2(TABLE_ROWS);
   localparam int RowLen    = HISTORY_LEN + 1;
   localparam int RowW      = RowLen * WEIGHT_BITS;
   localparam int SumW      = WEIGHT_BITS + $clog2(RowLen) + 1;
   localparam int GroupLen  = 8;
   localparam int NumGroups = (RowLen + GroupLen - 1) / GroupLen;
   localparam int MagW      = (SumW > pbp_pkg::ThreshW) ? SumW : pbp_pkg::ThreshW;
   localparam int ClampW    = (SumW > pbp_pkg::SumFieldW) ? SumW : pbp_pkg::SumFieldW;

   // floor(2^32 / rows): quotient estimate is low by at most one
   localparam logic [63:0] RecipFull = (64'd1 << 32) / 64'(TABLE_ROWS);
   localparam logic [31:0] Recip     = RecipFull[31:0];
   localparam logic [31:0] RowsConst = 32'(TABLE_ROWS);
   localparam logic [IdxW-1:0] LastRow = IdxW'(TABLE_ROWS - 1);

   localparam logic signed [WEIGHT_BITS-1:0] WMax = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
   localparam logic signed [WEIGHT_BITS-1:0] WMin = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
   localparam logic signed [ClampW-1:0] FieldMax =
      ClampW'((2 ** (pbp_pkg::SumFieldW - 1)) - 1);
   localparam logic signed [ClampW-1:0] FieldMin =
      ClampW'(-(2 ** (pbp_pkg::SumFieldW - 1)));

   function automatic logic signed [SumW-1:0] term_of(
      input logic [RowW-1:0]        row,
      input logic [HISTORY_LEN-1:0] hist,
      input int                     e
   );
      logic signed [WEIGHT_BITS-1:0] w;
      logic signed [SumW-1:0]        ext;
      w   = row[e*WEIGHT_BITS +: WEIGHT_BITS];
      ext = SumW'(w);
      if (e == 0) begin
         return ext;
      end else if (hist[e-1]) begin
         return ext;
      end else begin
         return -ext;
      end
   endfunction

   function automatic logic signed [WEIGHT_BITS-1:0] nudge(
      input logic signed [WEIGHT_BITS-1:0] w,
      input logic                          up
   );
      if (up) begin
         return (w == WMax) ? w : w + 1'b1;
      end else begin
         return (w == WMin) ? w : w - 1'b1;
      end
   endfunction

   // index pipeline
   logic [31:0]     hash_ff, hash_in;
   logic            taken_ff, taken_in;
   logic [31:0]     q_ff, q_in;
   logic [31:0]     qr_ff, qr_in;
   logic [IdxW-1:0] row_idx_ff, row_idx_in;
   logic [63:0]     q_product;
   logic [31:0]     rem, rem_fix;
   logic [IdxW-1:0] row_idx;

   // sum and decision
   logic [RowW-1:0]        row_data;
   logic signed [SumW-1:0] partial_ff [NumGroups];
   logic signed [SumW-1:0] partial_in [NumGroups];
   logic signed [SumW-1:0] sum_ff, sum_in;
   logic [SumW-1:0]        mag;
   logic signed [ClampW-1:0] sum_wide;
   logic                   pred_ff, pred_in;
   logic                   train_ff, train_in;
   logic signed [pbp_pkg::SumFieldW-1:0] field_ff, field_in;

   // architectural state and result register
   logic [HISTORY_LEN-1:0]      history_ff, history_in;
   logic [pbp_pkg::ThreshW-1:0] thresh_ff, thresh_in;
   logic [IdxW-1:0]             clear_idx_ff, clear_idx_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_pred_ff, rsp_pred_in;
   logic signed [pbp_pkg::SumFieldW-1:0] rsp_sum_ff, rsp_sum_in;
   logic                        rsp_upd_ff, rsp_upd_in;

   logic [RowW-1:0]  new_row;
   logic             ram_wr_en;
   logic [IdxW-1:0]  ram_wr_addr;
   logic [RowW-1:0]  ram_wr_data;

   // row index: (addr * 19) mod 2^32, reduced mod rows by reciprocal multiply
   always_comb begin
      hash_in   = cmd.load ? req_branch_address * 32'(pbp_pkg::AddrMult) : hash_ff;
      taken_in  = cmd.load ? req_branch_taken : taken_ff;
      q_product = 64'(hash_ff) * 64'(Recip);
      q_in      = q_product[63:32];
      qr_in     = q_ff * RowsConst;
      rem       = hash_ff - qr_ff;
      rem_fix   = (rem >= RowsConst) ? rem - RowsConst : rem;
      row_idx   = rem_fix[IdxW-1:0];
      row_idx_in = cmd.read ? row_idx : row_idx_ff;
   end

   // first tree level: groups of up to eight signed terms
   always_comb begin
      for (int g = 0; g < NumGroups; g++) begin
         partial_in[g] = '0;
         for (int j = 0; j < GroupLen; j++) begin
            if (g * GroupLen + j < RowLen) begin
               partial_in[g] = partial_in[g] + term_of(row_data, history_ff, g * GroupLen + j);
            end
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int g = 0; g < NumGroups; g++) begin
         sum_in = sum_in + partial_ff[g];
      end
   end

   always_comb begin
      mag      = sum_ff[SumW-1] ? SumW'(-sum_ff) : SumW'(sum_ff);
      pred_in  = ~sum_ff[SumW-1];
      train_in = (pred_in != taken_ff) || (MagW'(mag) < MagW'(thresh_ff));
      sum_wide = ClampW'(sum_ff);
      if (sum_wide > FieldMax) begin
         field_in = pbp_pkg::SumFieldW'(FieldMax);
      end else if (sum_wide < FieldMin) begin
         field_in = pbp_pkg::SumFieldW'(FieldMin);
      end else begin
         field_in = sum_wide[pbp_pkg::SumFieldW-1:0];
      end
   end

   // trained row: bias toward outcome, others toward agreement with history
   always_comb begin
      for (int e = 0; e < RowLen; e++) begin
         if (e == 0) begin
            new_row[e*WEIGHT_BITS +: WEIGHT_BITS] =
               nudge(row_data[e*WEIGHT_BITS +: WEIGHT_BITS], taken_ff);
         end else begin
            new_row[e*WEIGHT_BITS +: WEIGHT_BITS] =
               nudge(row_data[e*WEIGHT_BITS +: WEIGHT_BITS], history_ff[e-1] == taken_ff);
         end
      end
   end

   always_comb begin
      history_in   = cmd.commit ? HISTORY_LEN'({history_ff, taken_ff}) : history_ff;
      thresh_in    = csr_write_enable ? csr_write_data : thresh_ff;
      clear_idx_in = cmd.clear ? clear_idx_ff + 1'b1 : clear_idx_ff;
      rsp_valid_in = cmd.commit | (rsp_valid_ff & ~rsp_ready);
      rsp_pred_in  = cmd.commit ? pred_ff : rsp_pred_ff;
      rsp_sum_in   = cmd.commit ? field_ff : rsp_sum_ff;
      rsp_upd_in   = cmd.commit ? train_ff : rsp_upd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff   <= '0;
         thresh_ff    <= pbp_pkg::ThreshReset;
         clear_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         history_ff   <= history_in;
         thresh_ff    <= thresh_in;
         clear_idx_ff <= clear_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff    <= hash_in;
      taken_ff   <= taken_in;
      q_ff       <= q_in;
      qr_ff      <= qr_in;
      row_idx_ff <= row_idx_in;
      for (int g = 0; g < NumGroups; g++) begin
         partial_ff[g] <= partial_in[g];
      end
      sum_ff      <= sum_in;
      pred_ff     <= pred_in;
      train_ff    <= train_in;
      field_ff    <= field_in;
      rsp_pred_ff <= rsp_pred_in;
      rsp_sum_ff  <= rsp_sum_in;
      rsp_upd_ff  <= rsp_upd_in;
   end

   assign ram_wr_en   = cmd.clear | (cmd.commit & train_ff);
   assign ram_wr_addr = cmd.clear ? clear_idx_ff : row_idx_ff;
   assign ram_wr_data = cmd.clear ? '0 : new_row;

   pbp_ram #(
      .WIDTH (RowW),
      .DEPTH (TABLE_ROWS)
   ) u_weights (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.read),
      .rd_addr (row_idx),
      .rd_data (row_data)
   );

   assign status.clear_last = (clear_idx_ff == LastRow);
   assign status.out_busy   = rsp_valid_ff & ~rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_predicted_taken = rsp_pred_ff;
   assign rsp_weighted_sum    = rsp_sum_ff;
   assign rsp_weights_updated = rsp_upd_ff;

endmodule

@@ sv/perceptron_branch_predictor_core.sv @@
// Path from req accept to rsp_valid: hash multiply, reciprocal row reduction,
// row read, two-level sum, decide, writeback; writeback waits while the previous result is unclaimed.
// Occupancy: the sequencer holds one item at a time, and the weight row RAM
// is read once and written at most once per item.
// Reset: synchronous; the weight table is then zeroed one row per cycle, every
// row, with req_ready low. csr writes are taken throughout.
module perceptron_branch_predictor_core #(
   parameter int TABLE_ROWS  = 512,
   parameter int HISTORY_LEN = 20,
   parameter int WEIGHT_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [pbp_pkg::AddrW-1:0]            req_branch_address,
   input  logic                                 req_branch_taken,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_predicted_taken,
   output logic signed [pbp_pkg::SumFieldW-1:0] rsp_weighted_sum,
   output logic                                 rsp_weights_updated,
   input  logic                                 csr_write_enable,
   input  logic [pbp_pkg::ThreshW-1:0]          csr_write_data
);

   pbp_pkg::cmd_type    cmd;
   pbp_pkg::status_type status;

   pbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   pbp_datapath #(
      .TABLE_ROWS  (TABLE_ROWS),
      .HISTORY_LEN (HISTORY_LEN),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_branch_address  (req_branch_address),
      .req_branch_taken    (req_branch_taken),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_predicted_taken (rsp_predicted_taken),
      .rsp_weighted_sum    (rsp_weighted_sum),
      .rsp_weights_updated (rsp_weights_updated),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

endmodule

@@ sv/pbp_checker.sv @@
module pbp_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 rsp_predicted_taken,
   input logic signed [pbp_pkg::SumFieldW-1:0] rsp_weighted_sum,
   input logic                                 rsp_weights_updated
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_weighted_sum)
         && $stable(rsp_predicted_taken) && $stable(rsp_weights_updated))
      else $error("stalled result changed");

   // prediction is the sign of the sum; clamping keeps the sign
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_predicted_taken == !rsp_weighted_sum[pbp_pkg::SumFieldW-1])
      else $error("prediction disagrees with sum sign");

   // one item in flight
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while busy");

   // each rising rsp_valid traces back to an accepted item
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 8))
      else $error("result without matching item");

endmodule

bind perceptron_branch_predictor_core pbp_checker u_checker (.*);
